// ===== rtl/bpa_pkg.sv =====
// ---------------------------------------------------------------------------
// Buddy page allocator package
// Types, constants and helpers shared by the allocator modules.
// ---------------------------------------------------------------------------
package bpa_pkg;

   localparam int ZONE_PAGES = 4096;
   localparam int TOP_ORDER  = 10;
   localparam int PAGE_BITS  = 20;
   localparam int END_BITS   = PAGE_BITS + 1;
   localparam int ORDER_BITS = 4;
   localparam int ADDR_BITS  = $clog2(ZONE_PAGES);
   localparam int LINK_BITS  = ADDR_BITS + 1;
   localparam int LIST_BITS  = $clog2(TOP_ORDER + 1);
   localparam logic [LINK_BITS-1:0] NIL_LINK = LINK_BITS'(ZONE_PAGES);

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_RELEASE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_BLOCK = 2'd1,
      ST_ORDER    = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic {
      CSR_ZONE_FIRST = 1'b0,
      CSR_ZONE_END   = 1'b1
   } csr_type;

   typedef struct packed {
      op_type                  op;
      logic [ORDER_BITS-1:0]   order;
      logic [PAGE_BITS-1:0]    page_index;
      logic [END_BITS-1:0]     range_end;
   } req_type;

   typedef struct packed {
      logic [PAGE_BITS-1:0]    result_page;
      status_type              status;
   } rsp_type;

   typedef struct packed {
      logic                    free;
      logic [ORDER_BITS-1:0]   order;
      logic [LINK_BITS-1:0]    next;
      logic [LINK_BITS-1:0]    prev;
   } entry_type;

   typedef struct packed {
      logic                    rd_en;
      logic [ADDR_BITS-1:0]    rd_addr;
      logic                    wr_en;
      logic [ADDR_BITS-1:0]    wr_addr;
      logic                    wr_meta;
      logic                    wr_next;
      logic                    wr_prev;
      entry_type               wr_data;
   } mem_ctl_type;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE,
      S_U_RD, S_U_P, S_U_N, S_U_R,
      S_P_RD, S_P_CHK, S_P_LINK, S_P_FIX,
      S_AL_SPLIT,
      S_F_RD, S_F_CHK, S_F_LOOP, S_F_BRD, S_F_BCHK, S_F_MERGE, S_F_PUSH,
      S_R_LOOP, S_R_NEXT,
      S_DONE
   } state_type;

   function automatic logic is_nil(input logic [LINK_BITS-1:0] link);
      return link >= NIL_LINK;
   endfunction

endpackage

// ===== rtl/buddy_page_allocator_unit.sv =====
// ---------------------------------------------------------------------------
// Buddy page allocator
// Allocate, free and release page blocks over one zone with per-order
// free lists kept in an on-chip page store.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake               | beat
//  req      | in        | req_valid / req_stall   | req_type (op, order, page, end)
//  rsp      | out       | rsp_valid / rsp_stall   | rsp_type (result_page, status)
//  csr      | in        | csr_valid / csr_ready   | csr_index, csr_wdata
//
//  One request at a time; allocate unlinks a block and splits it level by level, free
//  merges with free buddies level by level and then pushes, release pushes block by
//  block, all set by the page store read-modify-write sequence.
//  After reset a clearing pass over all ZONE_PAGES (4096) entries holds req_stall high.
//  A finished beat waits in the rsp register while the next request is taken.
// ---------------------------------------------------------------------------
module buddy_page_allocator_unit
   import bpa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  csr_type             csr_index,
   input  logic [END_BITS-1:0] csr_wdata
);

   logic [PAGE_BITS-1:0] zone_first_ff;
   logic [END_BITS-1:0]  zone_end_ff, zone_lim, eff_end;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, eng_rsp;
   logic                 out_free, eng_idle, eng_done, start;
   mem_ctl_type          mem_ctl;
   entry_type            rd_entry;

   assign csr_ready = 1'b1;
   assign zone_lim  = {1'b0, zone_first_ff} + END_BITS'(ZONE_PAGES);
   assign eff_end   = (zone_end_ff < zone_lim) ? zone_end_ff : zone_lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_first_ff <= '0;
         zone_end_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ZONE_FIRST: zone_first_ff <= csr_wdata[PAGE_BITS-1:0];
            CSR_ZONE_END:   zone_end_ff   <= csr_wdata;
            default:        zone_end_ff   <= zone_end_ff;
         endcase
      end
   end

   assign req_stall = !eng_idle;
   assign start     = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (eng_done && out_free) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_done && out_free) begin
         rsp_ff <= eng_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   bpa_page_store u_store (
      .clock    (clock),
      .mem_ctl  (mem_ctl),
      .rd_entry (rd_entry)
   );

   bpa_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req_data),
      .zone_first (zone_first_ff),
      .eff_end    (eff_end),
      .out_free   (out_free),
      .rd_entry   (rd_entry),
      .mem_ctl    (mem_ctl),
      .idle       (eng_idle),
      .done       (eng_done),
      .rsp        (eng_rsp)
   );

endmodule

// ===== rtl/bpa_page_store.sv =====
// ---------------------------------------------------------------------------
// Buddy page store
// Per-page memory of free flag, order and list links, with field write
// enables and a registered read port.
// ---------------------------------------------------------------------------
module bpa_page_store
   import bpa_pkg::*;
(
   input  logic        clock,
   input  mem_ctl_type mem_ctl,
   output entry_type   rd_entry
);

   entry_type mem_array [ZONE_PAGES];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         if (mem_ctl.wr_meta) begin
            mem_array[mem_ctl.wr_addr].free  <= mem_ctl.wr_data.free;
            mem_array[mem_ctl.wr_addr].order <= mem_ctl.wr_data.order;
         end
         if (mem_ctl.wr_next) begin
            mem_array[mem_ctl.wr_addr].next <= mem_ctl.wr_data.next;
         end
         if (mem_ctl.wr_prev) begin
            mem_array[mem_ctl.wr_addr].prev <= mem_ctl.wr_data.prev;
         end
      end
      if (mem_ctl.rd_en) begin
         rd_entry_ff <= mem_array[mem_ctl.rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== rtl/bpa_engine.sv =====
// ---------------------------------------------------------------------------
// Buddy allocator sequencer
// Runs allocate, free and release over the page store and the list heads.
// ---------------------------------------------------------------------------
module bpa_engine
   import bpa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  req_type              req,
   input  logic [PAGE_BITS-1:0] zone_first,
   input  logic [END_BITS-1:0]  eff_end,
   input  logic                 out_free,
   input  entry_type            rd_entry,
   output mem_ctl_type          mem_ctl,
   output logic                 idle,
   output logic                 done,
   output rsp_type              rsp
);

   state_type state_ff, state_in, u_ret_ff, u_ret_in, p_ret_ff, p_ret_in;
   logic                  tail_ff, tail_in;
   logic [ORDER_BITS-1:0] order_ff, order_in, tgt_ff, tgt_in;
   logic [END_BITS-1:0]   page_ff, page_in, end_ff, end_in;
   logic [ADDR_BITS-1:0]  r_ff, r_in, clr_ff, clr_in;
   logic [LINK_BITS-1:0]  nb_ff, nb_in;
   status_type            status_ff, status_in;
   logic [PAGE_BITS-1:0]  result_ff, result_in;
   logic [LINK_BITS-1:0]  head_ff [TOP_ORDER+1];
   logic [LINK_BITS-1:0]  head_in [TOP_ORDER+1];
   logic [LINK_BITS-1:0]  ltail_ff [TOP_ORDER+1];
   logic [LINK_BITS-1:0]  ltail_in [TOP_ORDER+1];

   logic [END_BITS-1:0]   first_ext, pg_ext, fr_size, rel_b, rel_diff;
   logic [END_BITS-1:0]   bud_lo, bud_lo_rel, bud_f, page_rel;
   logic [ORDER_BITS-1:0] tdec, found_c, rel_o;
   logic [TOP_ORDER:0]    avail;
   logic                  order_ok, found_any, fr_bad, rel_empty, rel_bad;
   logic                  go_alloc, go_free, go_rel, lo_in_store, f_in_zone;
   logic [LIST_BITS-1:0]  tgt_idx, ord_idx;
   status_type            idle_status;

   assign first_ext = {1'b0, zone_first};
   assign pg_ext    = {1'b0, req.page_index};
   assign tgt_idx   = tgt_ff[LIST_BITS-1:0];
   assign ord_idx   = rd_entry.order[LIST_BITS-1:0];
   assign order_ok  = req.order <= ORDER_BITS'(TOP_ORDER);

   always_comb begin
      found_c = '0;
      for (int i = 0; i <= TOP_ORDER; i++) begin
         avail[i] = !is_nil(head_ff[i]) && (ORDER_BITS'(i) >= req.order);
      end
      for (int i = TOP_ORDER; i >= 0; i--) begin
         if (avail[i]) begin
            found_c = ORDER_BITS'(i);
         end
      end
   end
   assign found_any = |avail;

   assign fr_size   = END_BITS'(1) << req.order;
   assign fr_bad    = (pg_ext < first_ext) || (pg_ext + fr_size > eff_end)
                      || ((pg_ext & (fr_size - END_BITS'(1))) != '0);
   assign rel_b     = (req.page_index == '0) ? END_BITS'(1) : pg_ext;
   assign rel_empty = rel_b >= req.range_end;
   assign rel_bad   = (rel_b < first_ext) || (req.range_end > eff_end);

   assign go_alloc = order_ok && found_any;
   assign go_free  = (req.page_index != '0) && order_ok && !fr_bad;
   assign go_rel   = !rel_empty && !rel_bad;

   always_comb begin
      idle_status = ST_OK;
      unique case (req.op)
         OP_ALLOC: begin
            if (!order_ok) idle_status = ST_ORDER;
            else if (!found_any) idle_status = ST_NO_BLOCK;
         end
         OP_FREE: begin
            if (req.page_index == '0) idle_status = ST_OK;
            else if (!order_ok) idle_status = ST_ORDER;
            else if (fr_bad) idle_status = ST_RANGE;
         end
         OP_RELEASE: begin
            if (!rel_empty && rel_bad) idle_status = ST_RANGE;
         end
         OP_NONE: idle_status = ST_OK;
         default: idle_status = ST_OK;
      endcase
   end

   assign tdec        = tgt_ff - ORDER_BITS'(1);
   assign bud_lo      = page_ff ^ (END_BITS'(1) << tdec);
   assign bud_lo_rel  = bud_lo - first_ext;
   assign lo_in_store = (bud_lo >= first_ext) && (bud_lo_rel < END_BITS'(ZONE_PAGES));
   assign bud_f       = page_ff ^ (END_BITS'(1) << tgt_ff);
   assign f_in_zone   = (bud_f >= first_ext) && (bud_f < eff_end);
   assign page_rel    = page_ff - first_ext;
   assign rel_diff    = end_ff - page_ff;

   always_comb begin
      rel_o = ORDER_BITS'(TOP_ORDER);
      for (int o = TOP_ORDER - 1; o >= 0; o--) begin
         if (page_ff[o] || ((rel_diff >> (o + 1)) == '0)) begin
            rel_o = ORDER_BITS'(o);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      u_ret_in = u_ret_ff;
      p_ret_in = p_ret_ff;
      unique case (state_ff)
         S_CLR: if (clr_ff == ADDR_BITS'(ZONE_PAGES - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (start) begin
               state_in = S_DONE;
               unique case (req.op)
                  OP_ALLOC: if (go_alloc) begin
                     state_in = S_U_RD;
                     u_ret_in = S_AL_SPLIT;
                  end
                  OP_FREE:    if (go_free) state_in = S_F_RD;
                  OP_RELEASE: if (go_rel) state_in = S_R_LOOP;
                  OP_NONE:    state_in = S_DONE;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_U_RD:   state_in = S_U_P;
         S_U_P:    state_in = S_U_N;
         S_U_N:    state_in = S_U_R;
         S_U_R:    state_in = u_ret_ff;
         S_P_RD:   state_in = S_P_CHK;
         S_P_CHK: begin
            if (rd_entry.free) begin
               state_in = S_U_P;
               u_ret_in = S_P_LINK;
            end else begin
               state_in = S_P_LINK;
            end
         end
         S_P_LINK: state_in = S_P_FIX;
         S_P_FIX:  state_in = p_ret_ff;
         S_AL_SPLIT: begin
            if (tgt_ff > order_ff) begin
               if (lo_in_store) begin
                  state_in = S_P_RD;
                  p_ret_in = S_AL_SPLIT;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_F_RD:  state_in = S_F_CHK;
         S_F_CHK: state_in = rd_entry.free ? S_DONE : S_F_LOOP;
         S_F_LOOP: begin
            if ((tgt_ff < ORDER_BITS'(TOP_ORDER)) && f_in_zone) state_in = S_F_BRD;
            else state_in = S_F_PUSH;
         end
         S_F_BRD: state_in = S_F_BCHK;
         S_F_BCHK: begin
            if (rd_entry.free && (rd_entry.order == tgt_ff)) begin
               state_in = S_U_P;
               u_ret_in = S_F_MERGE;
            end else begin
               state_in = S_F_PUSH;
            end
         end
         S_F_MERGE: state_in = S_F_LOOP;
         S_F_PUSH: begin
            state_in = S_P_RD;
            p_ret_in = S_DONE;
         end
         S_R_LOOP: begin
            if (page_ff < end_ff) begin
               state_in = S_P_RD;
               p_ret_in = S_R_NEXT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_R_NEXT: state_in = S_R_LOOP;
         S_DONE:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // memory port
   always_comb begin
      mem_ctl = '0;
      unique case (state_ff)
         S_CLR: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = clr_ff;
            mem_ctl.wr_meta = 1'b1;
         end
         S_U_RD, S_P_RD, S_F_RD, S_F_BRD: begin
            mem_ctl.rd_en   = 1'b1;
            mem_ctl.rd_addr = r_ff;
         end
         S_U_P: begin
            mem_ctl.wr_en        = !is_nil(rd_entry.prev);
            mem_ctl.wr_addr      = rd_entry.prev[ADDR_BITS-1:0];
            mem_ctl.wr_next      = 1'b1;
            mem_ctl.wr_data.next = rd_entry.next;
         end
         S_U_N: begin
            mem_ctl.wr_en        = !is_nil(rd_entry.next);
            mem_ctl.wr_addr      = rd_entry.next[ADDR_BITS-1:0];
            mem_ctl.wr_prev      = 1'b1;
            mem_ctl.wr_data.prev = rd_entry.prev;
         end
         S_U_R: begin
            mem_ctl.wr_en         = 1'b1;
            mem_ctl.wr_addr       = r_ff;
            mem_ctl.wr_meta       = 1'b1;
            mem_ctl.wr_data.order = rd_entry.order;
         end
         S_P_LINK: begin
            mem_ctl.wr_en         = 1'b1;
            mem_ctl.wr_addr       = r_ff;
            mem_ctl.wr_meta       = 1'b1;
            mem_ctl.wr_next       = 1'b1;
            mem_ctl.wr_prev       = 1'b1;
            mem_ctl.wr_data.free  = 1'b1;
            mem_ctl.wr_data.order = tgt_ff;
            mem_ctl.wr_data.next  = tail_ff ? NIL_LINK : head_ff[tgt_idx];
            mem_ctl.wr_data.prev  = tail_ff ? ltail_ff[tgt_idx] : NIL_LINK;
         end
         S_P_FIX: begin
            mem_ctl.wr_en        = !is_nil(nb_ff);
            mem_ctl.wr_addr      = nb_ff[ADDR_BITS-1:0];
            mem_ctl.wr_next      = tail_ff;
            mem_ctl.wr_prev      = !tail_ff;
            mem_ctl.wr_data.next = {1'b0, r_ff};
            mem_ctl.wr_data.prev = {1'b0, r_ff};
         end
         default: mem_ctl = '0;
      endcase
   end

   // datapath
   always_comb begin
      tail_in   = tail_ff;
      order_in  = order_ff;
      tgt_in    = tgt_ff;
      page_in   = page_ff;
      end_in    = end_ff;
      r_in      = r_ff;
      nb_in     = nb_ff;
      status_in = status_ff;
      result_in = result_ff;
      clr_in    = clr_ff;
      head_in   = head_ff;
      ltail_in  = ltail_ff;
      unique case (state_ff)
         S_CLR: clr_in = clr_ff + ADDR_BITS'(1);
         S_IDLE: begin
            if (start) begin
               status_in = idle_status;
               result_in = '0;
               order_in  = req.order;
               tail_in   = (req.op == OP_RELEASE);
               unique case (req.op)
                  OP_ALLOC: begin
                     tgt_in  = found_c;
                     r_in    = head_ff[found_c[LIST_BITS-1:0]][ADDR_BITS-1:0];
                     page_in = first_ext
                               + END_BITS'(head_ff[found_c[LIST_BITS-1:0]][ADDR_BITS-1:0]);
                  end
                  OP_FREE: begin
                     tgt_in  = req.order;
                     page_in = pg_ext;
                     r_in    = ADDR_BITS'(pg_ext - first_ext);
                  end
                  OP_RELEASE: begin
                     page_in = rel_b;
                     end_in  = req.range_end;
                  end
                  OP_NONE: result_in = '0;
                  default: result_in = '0;
               endcase
            end
         end
         S_U_P: if (is_nil(rd_entry.prev)) head_in[ord_idx] = rd_entry.next;
         S_U_N: if (is_nil(rd_entry.next)) ltail_in[ord_idx] = rd_entry.prev;
         S_P_LINK: nb_in = tail_ff ? ltail_ff[tgt_idx] : head_ff[tgt_idx];
         S_P_FIX: begin
            if (tail_ff) begin
               ltail_in[tgt_idx] = {1'b0, r_ff};
               if (is_nil(nb_ff)) head_in[tgt_idx] = {1'b0, r_ff};
            end else begin
               head_in[tgt_idx] = {1'b0, r_ff};
               if (is_nil(nb_ff)) ltail_in[tgt_idx] = {1'b0, r_ff};
            end
         end
         S_AL_SPLIT: begin
            if (tgt_ff > order_ff) begin
               tgt_in = tdec;
               r_in   = bud_lo_rel[ADDR_BITS-1:0];
            end else begin
               result_in = page_ff[PAGE_BITS-1:0];
            end
         end
         S_F_CHK: if (rd_entry.free) status_in = ST_RANGE;
         S_F_LOOP: r_in = ADDR_BITS'(bud_f - first_ext);
         S_F_MERGE: begin
            page_in = page_ff & ~(END_BITS'(1) << tgt_ff);
            tgt_in  = tgt_ff + ORDER_BITS'(1);
         end
         S_F_PUSH: r_in = page_rel[ADDR_BITS-1:0];
         S_R_LOOP: begin
            tgt_in = rel_o;
            r_in   = page_rel[ADDR_BITS-1:0];
         end
         S_R_NEXT: page_in = page_ff + (END_BITS'(1) << tgt_ff);
         default: clr_in = clr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         u_ret_ff <= S_IDLE;
         p_ret_ff <= S_IDLE;
         clr_ff   <= '0;
         for (int i = 0; i <= TOP_ORDER; i++) begin
            head_ff[i]  <= NIL_LINK;
            ltail_ff[i] <= NIL_LINK;
         end
      end else begin
         state_ff <= state_in;
         u_ret_ff <= u_ret_in;
         p_ret_ff <= p_ret_in;
         clr_ff   <= clr_in;
         head_ff  <= head_in;
         ltail_ff <= ltail_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff   <= tail_in;
      order_ff  <= order_in;
      tgt_ff    <= tgt_in;
      page_ff   <= page_in;
      end_ff    <= end_in;
      r_ff      <= r_in;
      nb_ff     <= nb_in;
      status_ff <= status_in;
      result_ff <= result_in;
   end

   assign idle            = (state_ff == S_IDLE);
   assign done            = (state_ff == S_DONE);
   assign rsp.result_page = result_ff;
   assign rsp.status      = status_ff;

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.rd_en && mem_ctl.wr_en))
      else $error("store read and write in the same cycle");

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLR) |=> (state_ff != S_CLR))
      else $error("clearing pass restarted without reset");

   a_result_alloc: assert property (@(posedge clock) disable iff (reset)
      (done && (result_ff != '0)) |-> (status_ff == ST_OK))
      else $error("nonzero result page with error status");

   a_push_fix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_P_LINK) |=> (state_ff == S_P_FIX) && $stable(r_ff))
      else $error("push link step lost its page");

endmodule
